// ===== design/iirdf1_pkg.sv =====
package iirdf1_pkg;

   localparam int DEFAULT_TAPS = 20;
   localparam int SAMPLE_W     = 24;
   localparam int COEF_W       = 32;
   localparam int PROD_W       = SAMPLE_W + COEF_W;
   localparam int FRAC_SHIFT   = 24;
   localparam int INDEX_W      = 5;
   localparam int FUNC_W       = 2;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_WR_FF  = 2'd1,
      FUNC_WR_FB  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic sample_load;
      logic mac_issue;
      logic mac_fb;
      logic ff_write;
      logic fb_write;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== design/iirdf1_ctrl.sv =====
module iirdf1_ctrl
   import iirdf1_pkg::*;
#(
   parameter int TAPS = DEFAULT_TAPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [FUNC_W-1:0]    req_func,
   output logic                 req_ready,
   input  status_type           stat,
   output cmd_type              cmd,
   output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] mac_tap
);

   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W = TAP_W + 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               last_step;

   // Even counts are feedforward taps, odd counts are feedback taps.
   assign mac_tap   = cnt_ff[CNT_W-1:1];
   assign last_step = (cnt_ff[CNT_W-1:1] == TAP_W'(TAPS - 1)) && cnt_ff[0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && (req_func == FUNC_SAMPLE)) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_ROUND;
         ST_ROUND: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.sample_load = req_valid && (req_func == FUNC_SAMPLE);
            cmd.ff_write    = req_valid && (req_func == FUNC_WR_FF);
            cmd.fb_write    = req_valid && (req_func == FUNC_WR_FB);
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_fb    = cnt_ff[0];
         end
         ST_ROUND: begin
            cmd.publish = stat.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/iirdf1_datapath.sv =====
module iirdf1_datapath
   import iirdf1_pkg::*;
#(
   parameter int TAPS = DEFAULT_TAPS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] mac_tap,
   output status_type                  stat,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   input  logic [INDEX_W-1:0]          req_coef_index,
   input  logic signed [COEF_W-1:0]    req_coef_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic                        rsp_clipped
);

   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int ACC_W = PROD_W + TAP_W + 2;
   localparam int TOP_W = ACC_W - (FRAC_SHIFT + SAMPLE_W - 1);

   logic signed [COEF_W-1:0]   ff_mem [TAPS];
   logic signed [COEF_W-1:0]   fb_mem [TAPS];

   logic signed [SAMPLE_W-1:0] x_ff [TAPS];
   logic signed [SAMPLE_W-1:0] x_in [TAPS];
   logic signed [SAMPLE_W-1:0] y_ff [TAPS];
   logic signed [SAMPLE_W-1:0] y_in [TAPS];

   logic                       iss_v_ff, iss_neg_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic signed [SAMPLE_W-1:0] op_ff;
   logic                       prod_v_ff, prod_neg_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    prod_ext;

   logic [ACC_W-1:0]           rnd_sum;
   logic [TOP_W-1:0]           rnd_top;
   logic                       overflow;
   logic [SAMPLE_W-1:0]        result;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_sample_ff;
   logic                       rsp_clipped_ff;
   logic                       coef_idx_ok;

   assign coef_idx_ok = (32'(req_coef_index) < TAPS);

   always_ff @(posedge clock) begin
      if (coef_idx_ok && cmd.ff_write) begin
         ff_mem[TAP_W'(req_coef_index)] <= req_coef_value;
      end
      if (coef_idx_ok && cmd.fb_write) begin
         fb_mem[TAP_W'(req_coef_index)] <= req_coef_value;
      end
      if (cmd.mac_issue) begin
         coef_rd_ff <= cmd.mac_fb ? fb_mem[mac_tap] : ff_mem[mac_tap];
      end
   end

   // Rounding: add half an output LSB, keep the integer part, then check
   // that all bits above the 24-bit result agree with its sign.
   assign rnd_sum  = acc_ff + (ACC_W'(1) << (FRAC_SHIFT - 1));
   assign rnd_top  = rnd_sum[ACC_W-1:FRAC_SHIFT+SAMPLE_W-1];
   assign overflow = !((&rnd_top) || !(|rnd_top));
   assign result   = overflow ? (rnd_sum[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                              : rnd_sum[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];

   // The histories are read only at entry zero. Each MAC step rotates the
   // history it used, so after all taps both are back in their original order.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         x_in[i] = x_ff[i];
         y_in[i] = y_ff[i];
      end
      if (cmd.sample_load) begin
         x_in[0] = req_sample_in;
         for (int i = 1; i < TAPS; i++) begin
            x_in[i] = x_ff[i-1];
         end
      end else if (cmd.mac_issue && !cmd.mac_fb) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            x_in[i] = x_ff[i+1];
         end
         x_in[TAPS-1] = x_ff[0];
      end
      if (cmd.publish) begin
         y_in[0] = result;
         for (int i = 1; i < TAPS; i++) begin
            y_in[i] = y_ff[i-1];
         end
      end else if (cmd.mac_issue && cmd.mac_fb) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            y_in[i] = y_ff[i+1];
         end
         y_in[TAPS-1] = y_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            x_ff[i] <= '0;
            y_ff[i] <= '0;
         end
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign prod_ext = ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         iss_v_ff  <= cmd.mac_issue;
         prod_v_ff <= iss_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_issue) begin
         op_ff      <= cmd.mac_fb ? y_ff[0] : x_ff[0];
         iss_neg_ff <= cmd.mac_fb;
      end
      if (iss_v_ff) begin
         prod_ff     <= coef_rd_ff * op_ff;
         prod_neg_ff <= iss_neg_ff;
      end
      if (cmd.sample_load) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= prod_neg_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_sample_ff  <= result;
         rsp_clipped_ff <= overflow;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

// ===== design/iir_filter_direct_form_one_core.sv =====
// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_ready  func, sample_in, coef_index, coef_value
// rsp_     out        rsp_valid / rsp_ready  sample_out, clipped
//
// A sample request is taken in the idle state, then makes one multiply-accumulate
// step per coefficient through a single shared multiplier, drains the multiplier
// pipeline in the DRAIN1 and DRAIN2 states, and rounds and saturates in ROUND.
// A coefficient write or an unused function code is complete once it is taken.
// Reset clears both sample histories; coefficients are not cleared.
// A finished result waits in the output register while the next request is
// taken; only the rounding step stalls until that register is free.
module iir_filter_direct_form_one_core
   import iirdf1_pkg::*;
#(
   parameter int TAPS = DEFAULT_TAPS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [FUNC_W-1:0]           req_func,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   input  logic [INDEX_W-1:0]          req_coef_index,
   input  logic signed [COEF_W-1:0]    req_coef_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic                        rsp_clipped
);

   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   cmd_type            cmd;
   status_type         stat;
   logic [TAP_W-1:0]   mac_tap;

   iirdf1_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd),
      .mac_tap   (mac_tap)
   );

   iirdf1_datapath #(
      .TAPS (TAPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .mac_tap        (mac_tap),
      .stat           (stat),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

endmodule

// ===== tb/sv/iir_filter_direct_form_one_core_tb.sv =====
module iir_filter_direct_form_one_core_tb;
   import iirdf1_pkg::*;

   localparam int TAPS_N = DEFAULT_TAPS;
   localparam int CLK_PERIOD = 12;
   localparam int MAX_REPORTS = 10;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [COEF_W-1:0] COEF_UNITY = 32'sh0100_0000;
   localparam logic [COEF_W-1:0] COEF_HALF = 32'sh0080_0000;
   localparam logic [COEF_W-1:0] COEF_POS_MAX = 32'sh7FFF_FFFF;
   localparam logic [COEF_W-1:0] COEF_NEG_MAX = 32'sh8000_0000;
   localparam longint OUT_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
   localparam longint OUT_LO = -(64'sd1 <<< (SAMPLE_W - 1));

   typedef enum int {
      COEF_GENTLE,
      COEF_MODERATE,
      COEF_WILD
   } coef_profile_type;

   class filter_tracker;
      typedef struct packed {
         logic [SAMPLE_W-1:0] value;
         logic                clip;
      } out_sample_type;

      logic signed [SAMPLE_W-1:0] x_hist[TAPS_N] = '{default: '0};
      logic signed [SAMPLE_W-1:0] y_hist[TAPS_N] = '{default: '0};
      logic signed [COEF_W-1:0]   b_coef[TAPS_N] = '{default: '0};
      logic signed [COEF_W-1:0]   a_coef[TAPS_N] = '{default: '0};
      out_sample_type pending_outputs[$];
      int mismatches = 0;

      function void flag(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", what);
      endfunction

      // Applies one accepted request to the filter state and queues the
      // output sample that a sample request must produce.
      function void take_request(logic [FUNC_W-1:0] f, logic [SAMPLE_W-1:0] s,
                                 logic [INDEX_W-1:0] idx, logic [COEF_W-1:0] c);
         longint acc;
         longint rounded;
         logic clip;
         out_sample_type res;
         int k;
         case (f)
            FUNC_WR_FF: begin
               if (idx < TAPS_N)
                  b_coef[idx] = c;
            end
            FUNC_WR_FB: begin
               if (idx < TAPS_N)
                  a_coef[idx] = c;
            end
            FUNC_SAMPLE: begin
               for (k = TAPS_N - 1; k > 0; k--)
                  x_hist[k] = x_hist[k-1];
               x_hist[0] = s;
               acc = 0;
               for (k = 0; k < TAPS_N; k++) begin
                  acc += longint'(b_coef[k]) * longint'(x_hist[k]);
                  acc -= longint'(a_coef[k]) * longint'(y_hist[k]);
               end
               // Adding half an LSB before the arithmetic shift rounds ties upward.
               rounded = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
               clip = 1'b0;
               if (rounded > OUT_HI) begin
                  rounded = OUT_HI;
                  clip = 1'b1;
               end else if (rounded < OUT_LO) begin
                  rounded = OUT_LO;
                  clip = 1'b1;
               end
               for (k = TAPS_N - 1; k > 0; k--)
                  y_hist[k] = y_hist[k-1];
               y_hist[0] = rounded[SAMPLE_W-1:0];
               res.value = rounded[SAMPLE_W-1:0];
               res.clip = clip;
               pending_outputs = {pending_outputs, res};
            end
            default: ;
         endcase
      endfunction

      function void check_output(logic [SAMPLE_W-1:0] v, logic c);
         out_sample_type want;
         if (pending_outputs.size() == 0) begin
            flag($sformatf("unexpected output sample_out=%0d clipped=%0b",
                           $signed(v), c));
            return;
         end
         want = pending_outputs.pop_front();
         if (v !== want.value)
            flag($sformatf("sample_out expected %0d actual %0d",
                           $signed(want.value), $signed(v)));
         if (c !== want.clip)
            flag($sformatf("clipped expected %0b actual %0b", want.clip, c));
      endfunction

      function void flush_leftovers();
         while (pending_outputs.size() > 0) begin
            flag($sformatf("missing output sample_out=%0d",
                           $signed(pending_outputs[0].value)));
            void'(pending_outputs.pop_front());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [FUNC_W-1:0] req_func;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic [INDEX_W-1:0] req_coef_index;
   logic signed [COEF_W-1:0] req_coef_value;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic rsp_clipped;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   filter_tracker book = new();

   iir_filter_direct_form_one_core #(
      .TAPS(TAPS_N)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_sample_in(req_sample_in),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .rsp_clipped(rsp_clipped)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_output(rsp_sample_out, rsp_clipped);
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back requests never toggle it.
   task automatic send_request(logic [FUNC_W-1:0] f, logic [SAMPLE_W-1:0] s,
                               logic [INDEX_W-1:0] idx, logic [COEF_W-1:0] c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_sample_in <= s;
      req_coef_index <= idx;
      req_coef_value <= c;
      do
         @(posedge clock);
      while (!req_ready);
      book.take_request(f, s, idx, c);
      @(negedge clock);
   endtask

   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      send_request(FUNC_SAMPLE, s, INDEX_W'($urandom()), $urandom());
   endtask

   task automatic send_coef(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                            logic [COEF_W-1:0] c);
      send_request(f, SAMPLE_W'($urandom()), idx, c);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return SAMPLE_W'($urandom());
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef(coef_profile_type profile);
      if ($urandom_range(19) == 0) begin
         case ($urandom_range(4))
            0: return COEF_POS_MAX;
            1: return COEF_NEG_MAX;
            2: return '0;
            3: return COEF_UNITY;
            default: return '1;
         endcase
      end
      case (profile)
         COEF_GENTLE: return int'($urandom_range(1 << 22)) - (1 << 21);
         COEF_MODERATE: return int'($urandom_range(1 << 25)) - (1 << 24);
         default: return $urandom();
      endcase
   endfunction

   task automatic load_coefs(coef_profile_type profile);
      int k;
      for (k = 0; k < TAPS_N; k++) begin
         send_coef(FUNC_WR_FF, INDEX_W'(k), pick_coef(profile));
         send_coef(FUNC_WR_FB, INDEX_W'(k), pick_coef(profile));
      end
   endtask

   task automatic run_random(int count, coef_profile_type profile);
      int n;
      int roll;
      logic [INDEX_W-1:0] idx;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 82) begin
            send_sample(pick_sample());
         end else if (roll < 96) begin
            // Now and then aim past the last tap so the ignored write is exercised.
            if ($urandom_range(9) == 0)
               idx = INDEX_W'($urandom_range(31));
            else
               idx = INDEX_W'($urandom_range(TAPS_N - 1));
            send_coef((roll < 89) ? FUNC_WR_FF : FUNC_WR_FB, idx, pick_coef(profile));
         end else begin
            send_request(FUNC_UNUSED, SAMPLE_W'($urandom()), INDEX_W'($urandom()),
                         $urandom());
         end
      end
   endtask

   initial begin
      #(600_000 * CLK_PERIOD);
      $display("FAIL");
      $finish;
   end

   initial begin
      int k;
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_SAMPLE;
      req_sample_in = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Pass-through setup: unity on the newest input, everything else zero.
      for (k = 0; k < TAPS_N; k++) begin
         send_coef(FUNC_WR_FF, INDEX_W'(k), (k == 0) ? COEF_UNITY : '0);
         send_coef(FUNC_WR_FB, INDEX_W'(k), '0);
      end
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(24'sd1);
      send_sample(-24'sd1);

      // A gain of one half puts odd inputs exactly on a rounding tie.
      send_coef(FUNC_WR_FF, 0, COEF_HALF);
      send_sample(24'sd1);
      send_sample(-24'sd1);
      send_sample(24'sd3);
      send_sample(-24'sd3);

      send_coef(FUNC_WR_FF, 0, COEF_POS_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_coef(FUNC_WR_FF, 0, COEF_NEG_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);

      send_coef(FUNC_WR_FF, 5'd31, 32'h1234_5678);
      send_coef(FUNC_WR_FB, 5'd20, COEF_POS_MAX);
      send_request(FUNC_UNUSED, SAMPLE_MAX, 5'd0, COEF_POS_MAX);

      // A negative feedback tap turns the filter into a running sum that
      // saturates and feeds the clipped value back.
      send_coef(FUNC_WR_FF, 0, COEF_UNITY);
      send_coef(FUNC_WR_FB, 0, -COEF_UNITY);
      send_sample(24'sd1000);
      send_sample(SAMPLE_MAX);
      send_sample(24'sd5);

      load_coefs(COEF_GENTLE);
      run_random(215, COEF_GENTLE);

      send_idle_pct = 64;
      load_coefs(COEF_MODERATE);
      run_random(215, COEF_MODERATE);

      send_idle_pct = 0;
      recv_stall_pct = 64;
      load_coefs(COEF_WILD);
      run_random(215, COEF_WILD);

      send_idle_pct = 26;
      recv_stall_pct = 26;
      load_coefs(COEF_GENTLE);
      run_random(215, COEF_GENTLE);

      req_valid <= 1'b0;
      waited = 0;
      while (book.pending_outputs.size() > 0 && waited < 20_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * TAPS_N + 8) @(posedge clock);
      book.flush_leftovers();
      if (book.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
